FILE: hw/rtl/rel_pkg.sv
// Shared types, constants and the quadrature transition table for the level and mute block.
package rel_pkg;

    // Channel count and derived widths.
    localparam int NUM_CHANNELS = 5;
    localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Payload field widths.
    localparam int CHAN_W  = 3;
    localparam int LEVEL_W = 10;
    localparam int DEB_W   = 8;
    localparam int DET_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_STEP     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_MAX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DETENT_COUNT   = 2'd3;

    // Configuration reset values.
    localparam logic [LEVEL_W-1:0] RST_LEVEL_STEP     = 10'd25;
    localparam logic [LEVEL_W-1:0] RST_LEVEL_MAX      = 10'd1000;
    localparam logic [DEB_W-1:0]   RST_DEBOUNCE_LIMIT = 8'd19;
    localparam logic [DET_W-1:0]   RST_DETENT_COUNT   = 3'd4;

    // Direction codes, two bits signed.
    localparam logic signed [1:0] DIR_NONE = 2'sb00;
    localparam logic signed [1:0] DIR_UP   = 2'sb01;
    localparam logic signed [1:0] DIR_DOWN = 2'sb11;

    // Phase pair with both pins idle high.
    localparam logic [1:0] PHASE_IDLE = 2'b11;

    // Configuration register set.
    typedef struct packed {
        logic [LEVEL_W-1:0] level_step;
        logic [LEVEL_W-1:0] level_max;
        logic [DEB_W-1:0]   debounce_limit;
        logic [DET_W-1:0]   detent_count;
    } t_cfg;

    // Per-channel state word held in the channel memory.
    typedef struct packed {
        logic [1:0]         last_phase;
        logic signed [3:0]  step_cnt;
        logic               btn_stable;
        logic               btn_last;
        logic [DEB_W-1:0]   hold_cnt;
        logic [LEVEL_W-1:0] level;
        logic               mute;
    } t_chan_state;

    localparam t_chan_state CHAN_STATE_RST = '{
        last_phase: PHASE_IDLE,
        step_cnt:   4'sd0,
        btn_stable: 1'b1,
        btn_last:   1'b1,
        hold_cnt:   '0,
        level:      '0,
        mute:       1'b0
    };

    // Events produced by one state update.
    typedef struct packed {
        logic signed [1:0] dir;
        logic              press;
    } t_upd_evt;

    // Quadrature transition table, indexed by {previous phase, current phase}.
    function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        unique case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  d = DIR_UP;
            4'd2, 4'd4, 4'd11, 4'd13: d = DIR_DOWN;
            default:                  d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

FILE: hw/rtl/rel_if.sv
// Handshake interfaces for the sample, result and configuration channels.
interface rel_smp_if;
    import rel_pkg::*;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] channel;
    logic              phase_a;
    logic              phase_b;
    logic              button_raw;

    modport source (output valid, channel, phase_a, phase_b, button_raw, input ready);
    modport sink   (input valid, channel, phase_a, phase_b, button_raw, output ready);
endinterface

interface rel_res_if;
    import rel_pkg::*;
    logic               valid;
    logic               ready;
    logic [CHAN_W-1:0]  channel_out;
    logic [LEVEL_W-1:0] level;
    logic               mute;
    logic signed [1:0]  detent_dir;
    logic               press_event;

    modport source (output valid, channel_out, level, mute, detent_dir, press_event,
                    input ready);
    modport sink   (input valid, channel_out, level, mute, detent_dir, press_event,
                    output ready);
endinterface

interface rel_cfg_if;
    import rel_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/rotary_encoder_level_and_mute.sv
// Top level of the multi-channel rotary encoder level and mute controller.
// Takes one pin sample per clock cycle and returns one result per sample through the update
// stage and the result register in turn. Channel state sits in a small memory: the
// sample's entry is read at acceptance, updated in the following cycle and written back as
// the result is registered; a sample for the channel just written takes the new state from a
// forwarding register, so samples of one channel may follow each other in every cycle.
// The memory read is registered and followed by the update stage; throughput is one
// transaction per cycle, and a stalled result holds back new samples only once both the
// update stage and the result register are full. Samples with a channel number past the last
// channel change no state and report zero level, mute, direction and press. Configuration
// writes are always taken and should be made only while no sample is in flight.
module rotary_encoder_level_and_mute
    import rel_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    rel_smp_if.sink   i_smp,
    rel_res_if.source o_res,
    rel_cfg_if.sink   i_cfg
);

    t_cfg               r_cfg;
    logic               smp_acc;
    logic               smp_in_rng;
    logic               out_free;
    logic               s1_fire;
    logic               r_s1_vld;
    logic [CHAN_W-1:0]  r_s1_chan;
    logic               r_s1_in_rng;
    logic [1:0]         r_s1_phase;
    logic               r_s1_raw;
    t_chan_state        cur_state;
    t_chan_state        nxt_state;
    t_upd_evt           evt;
    logic               r_out_vld;
    logic [CHAN_W-1:0]  r_out_chan;
    logic [LEVEL_W-1:0] r_out_level;
    logic               r_out_mute;
    logic signed [1:0]  r_out_dir;
    logic               r_out_press;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{level_step:     RST_LEVEL_STEP,
                       level_max:      RST_LEVEL_MAX,
                       debounce_limit: RST_DEBOUNCE_LIMIT,
                       detent_count:   RST_DETENT_COUNT};
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_LEVEL_STEP:     r_cfg.level_step     <= i_cfg.data[LEVEL_W-1:0];
                CFG_LEVEL_MAX:      r_cfg.level_max      <= i_cfg.data[LEVEL_W-1:0];
                CFG_DEBOUNCE_LIMIT: r_cfg.debounce_limit <= i_cfg.data[DEB_W-1:0];
                CFG_DETENT_COUNT:   r_cfg.detent_count   <= i_cfg.data[DET_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control.
    assign out_free    = !r_out_vld || o_res.ready;
    assign s1_fire     = r_s1_vld && out_free;
    assign i_smp.ready = !r_s1_vld || out_free;
    assign smp_acc     = i_smp.valid && i_smp.ready;
    assign smp_in_rng  = int'(i_smp.channel) < NUM_CHANNELS;

    // Update stage: holds the transaction while its state word is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (smp_acc) begin
            r_s1_vld <= 1'b1;
        end else if (s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (smp_acc) begin
            r_s1_chan   <= i_smp.channel;
            r_s1_in_rng <= smp_in_rng;
            r_s1_phase  <= {i_smp.phase_a, i_smp.phase_b};
            r_s1_raw    <= i_smp.button_raw;
        end
    end

    // Channel state memory.
    rel_chan_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (smp_acc && smp_in_rng),
        .i_rd_addr  (CH_IDX_W'(i_smp.channel)),
        .i_wr_en    (s1_fire && r_s1_in_rng),
        .i_wr_addr  (CH_IDX_W'(r_s1_chan)),
        .i_wr_data  (nxt_state),
        .o_rd_state (cur_state)
    );

    // State update.
    rel_update u_update (
        .i_cfg   (r_cfg),
        .i_cur   (cur_state),
        .i_phase (r_s1_phase),
        .i_raw   (r_s1_raw),
        .o_nxt   (nxt_state),
        .o_evt   (evt)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s1_fire) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_out_chan <= r_s1_chan;
            if (r_s1_in_rng) begin
                r_out_level <= nxt_state.level;
                r_out_mute  <= nxt_state.mute;
                r_out_dir   <= evt.dir;
                r_out_press <= evt.press;
            end else begin
                r_out_level <= '0;
                r_out_mute  <= 1'b0;
                r_out_dir   <= DIR_NONE;
                r_out_press <= 1'b0;
            end
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.channel_out = r_out_chan;
    assign o_res.level       = r_out_level;
    assign o_res.mute        = r_out_mute;
    assign o_res.detent_dir  = r_out_dir;
    assign o_res.press_event = r_out_press;

    // An out-of-range channel reports nothing but its number.
    a_out_of_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && int'(r_out_chan) >= NUM_CHANNELS) |->
            (r_out_level == '0 && !r_out_mute && r_out_dir == DIR_NONE && !r_out_press))
        else $error("out-of-range channel result carries state");

    // A press event always comes with a changed mute flag for that channel.
    a_press_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_in_rng && evt.press) |-> (nxt_state.mute != cur_state.mute))
        else $error("press did not toggle mute");

    // An update-stage transaction blocked by a full result register stays put.
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !out_free) |=> (r_s1_vld && $stable(r_s1_chan)))
        else $error("update stage lost a stalled transaction");

    // The direction code never takes the unused value.
    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_dir == DIR_NONE || r_out_dir == DIR_UP || r_out_dir == DIR_DOWN))
        else $error("invalid detent direction code");

endmodule

FILE: hw/rtl/rel_chan_store.sv
// Per-channel state memory with reset-valid bits and same-entry write forwarding.
module rel_chan_store
    import rel_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [CH_IDX_W-1:0] i_rd_addr,
    input  logic                i_wr_en,
    input  logic [CH_IDX_W-1:0] i_wr_addr,
    input  t_chan_state         i_wr_data,
    output t_chan_state         o_rd_state
);

    t_chan_state             mem [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_valid;
    t_chan_state             r_rd_data;
    logic                    r_rd_vld;
    logic                    r_fwd_hit;
    t_chan_state             r_fwd_data;

    // Memory array: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // Entry valid bits; an entry never written reads as the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    // A read that meets a write to the same entry takes the written word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_hit <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_fwd_data <= i_wr_data;
        end
    end

    always_comb begin
        priority if (r_fwd_hit) begin
            o_rd_state = r_fwd_data;
        end else if (r_rd_vld) begin
            o_rd_state = r_rd_data;
        end else begin
            o_rd_state = CHAN_STATE_RST;
        end
    end

endmodule

FILE: hw/rtl/rel_update.sv
// Next-state logic for one channel: quadrature count, level clamp, debounce and mute.
module rel_update
    import rel_pkg::*;
(
    input  t_cfg        i_cfg,
    input  t_chan_state i_cur,
    input  logic [1:0]  i_phase,
    input  logic        i_raw,
    output t_chan_state o_nxt,
    output t_upd_evt    o_evt
);

    logic signed [1:0]  delta;
    logic signed [4:0]  cnt;
    logic signed [4:0]  lim;
    logic               detent;
    logic signed [11:0] lv;
    logic signed [11:0] lv_max;

    always_comb begin
        o_nxt = i_cur;
        o_evt = '{dir: DIR_NONE, press: 1'b0};

        // Quadrature step count; a detent count of zero acts as one.
        delta = quad_delta({i_cur.last_phase, i_phase});
        cnt   = {i_cur.step_cnt[3], i_cur.step_cnt} + {{3{delta[1]}}, delta};
        lim   = (i_cfg.detent_count == '0) ? 5'sd1 : {2'b00, i_cfg.detent_count};
        detent = (cnt >= lim) || (cnt <= -lim);
        o_nxt.last_phase = i_phase;
        if (detent) begin
            o_nxt.step_cnt = 4'sd0;
            o_evt.dir      = (cnt > 5'sd0) ? DIR_UP : DIR_DOWN;
        end else begin
            o_nxt.step_cnt = cnt[3:0];
        end

        // Level moves one step per detent, clamped to zero and then to the maximum.
        lv_max = {2'b00, i_cfg.level_max};
        if (cnt > 5'sd0) begin
            lv = {2'b00, i_cur.level} + {2'b00, i_cfg.level_step};
        end else begin
            lv = {2'b00, i_cur.level} - {2'b00, i_cfg.level_step};
        end
        if (lv < 12'sd0) begin
            lv = 12'sd0;
        end
        if (lv > lv_max) begin
            lv = lv_max;
        end
        if (detent) begin
            o_nxt.level = lv[LEVEL_W-1:0];
        end

        // Button debounce; the hold count saturates at the limit.
        priority if (i_raw != i_cur.btn_last) begin
            o_nxt.btn_last = i_raw;
            o_nxt.hold_cnt = '0;
        end else if (i_cur.hold_cnt < i_cfg.debounce_limit) begin
            o_nxt.hold_cnt = i_cur.hold_cnt + 8'd1;
        end else begin
            o_nxt.hold_cnt = i_cfg.debounce_limit;
            if (i_raw != i_cur.btn_stable) begin
                o_nxt.btn_stable = i_raw;
                o_evt.press      = !i_raw;
            end
        end

        // A debounced press toggles the mute flag.
        if (o_evt.press) begin
            o_nxt.mute = !i_cur.mute;
        end
    end

endmodule

FILE: dv/rotary_encoder_level_and_mute_tb.sv
// Self-checking testbench for the rotary encoder level and mute controller.
`timescale 1ns / 1ps

module rotary_encoder_level_and_mute_tb;
    import rel_pkg::*;

    // One pin sample as the scanner delivers it.
    typedef struct packed {
        logic [CHAN_W-1:0] channel;
        logic              phase_a;
        logic              phase_b;
        logic              button_raw;
    } pin_sample;

    // One channel report as the block returns it.
    typedef struct packed {
        logic [CHAN_W-1:0]  channel_out;
        logic [LEVEL_W-1:0] level;
        logic               mute;
        logic signed [1:0]  detent_dir;
        logic               press_event;
    } level_report;

    // Directed row: a sample, and the report typed in where it is plain to see.
    typedef struct packed {
        pin_sample   s;
        logic        known;
        level_report want;
    } probe_row;

    // Register values and traffic shape of one test phase.
    typedef struct {
        int unsigned step_amt;
        int unsigned top;
        int unsigned deb;
        int unsigned det;
        int unsigned items;
        int unsigned stick;
        bit          steady;
    } regime;

    // Step added to the turn count, indexed by {previous phases, current phases}.
    localparam int QUAD_STEP [16] = '{0, 1, -1, 0, -1, 0, 0, 1, 1, 0, 0, -1, 0, -1, 1, 0};

    localparam int NUM_PROBES = 21;
    localparam probe_row PROBES [NUM_PROBES] = '{
        '{'{3'd0, 1'b1, 1'b1, 1'b1}, 1'b1, '{3'd0, 10'd0, 1'b0, DIR_NONE, 1'b0}},
        // One clockwise detent on channel 1.
        '{'{3'd1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{3'd1, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{3'd1, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{3'd1, 1'b1, 1'b1, 1'b1}, 1'b1, '{3'd1, 10'd25, 1'b0, DIR_UP, 1'b0}},
        // Back down to zero, then a second detent down that clamps at zero.
        '{'{3'd1, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{3'd1, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{3'd1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{3'd1, 1'b1, 1'b1, 1'b1}, 1'b1, '{3'd1, 10'd0, 1'b0, DIR_DOWN, 1'b0}},
        '{'{3'd1, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{3'd1, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
        '{'{3'd1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
        '{'{3'd1, 1'b1, 1'b1, 1'b1}, 1'b1, '{3'd1, 10'd0, 1'b0, DIR_DOWN, 1'b0}},
        // Both phases jump at once, which the table does not count.
        '{'{3'd2, 1'b0, 1'b0, 1'b1}, 1'b1, '{3'd2, 10'd0, 1'b0, DIR_NONE, 1'b0}},
        '{'{3'd2, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
        // Channels past the last one report zeros.
        '{'{3'd5, 1'b1, 1'b1, 1'b0}, 1'b1, '{3'd5, 10'd0, 1'b0, DIR_NONE, 1'b0}},
        '{'{3'd6, 1'b0, 1'b0, 1'b1}, 1'b1, '{3'd6, 10'd0, 1'b0, DIR_NONE, 1'b0}},
        '{'{3'd7, 1'b1, 1'b0, 1'b0}, 1'b1, '{3'd7, 10'd0, 1'b0, DIR_NONE, 1'b0}},
        // A short button glitch on channel 4 that the debounce must reject.
        '{'{3'd4, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
        '{'{3'd3, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{3'd4, 1'b1, 1'b0, 1'b1}, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    rel_smp_if smp_bus ();
    rel_res_if res_bus ();
    rel_cfg_if cfg_bus ();

    rotary_encoder_level_and_mute uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_bus),
        .o_res   (res_bus),
        .i_cfg   (cfg_bus)
    );

    always #10 i_clk = ~i_clk;

    // Predicted register contents.
    int cfg_step;
    int cfg_max;
    int cfg_debounce;
    int cfg_detents;

    // Predicted per-channel state.
    logic [1:0] pin_state   [NUM_CHANNELS];
    int         turn_count  [NUM_CHANNELS];
    logic       btn_settled [NUM_CHANNELS];
    logic       btn_prev    [NUM_CHANNELS];
    int         hold_q      [NUM_CHANNELS];
    int         level_q     [NUM_CHANNELS];
    logic       mute_q      [NUM_CHANNELS];

    level_report pending_reports [$];
    int          fail_count = 0;
    bit          steady_flow = 1'b0;

    // Stimulus state per channel: encoder position, spin sense, button level and run.
    logic [1:0]  enc_phase [8];
    logic        spin_cw   [8];
    logic        btn_level [8];
    int unsigned btn_run   [8];

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Advances the report of one channel by one sample.
    function automatic level_report predict_sample(input pin_sample s);
        level_report       r;
        logic [1:0]        ph;
        int                cnt;
        int                lim;
        int                lv;
        logic signed [1:0] d;
        logic              press;
        r = '0;
        r.channel_out = s.channel;
        if (s.channel >= NUM_CHANNELS) begin
            return r;
        end
        // Quadrature count and detent.
        ph  = {s.phase_a, s.phase_b};
        lim = (cfg_detents == 0) ? 1 : cfg_detents;
        cnt = turn_count[s.channel] + QUAD_STEP[{pin_state[s.channel], ph}];
        pin_state[s.channel] = ph;
        d = DIR_NONE;
        if (cnt >= lim || cnt <= -lim) begin
            turn_count[s.channel] = 0;
            d = (cnt > 0) ? DIR_UP : DIR_DOWN;
        end else begin
            turn_count[s.channel] = cnt;
        end
        // Level moves by one step and is clamped.
        if (d != DIR_NONE) begin
            lv = level_q[s.channel] + ((d == DIR_UP) ? cfg_step : -cfg_step);
            if (lv < 0) lv = 0;
            if (lv > cfg_max) lv = cfg_max;
            level_q[s.channel] = lv;
        end
        // Button debounce; only a settled press toggles the mute.
        press = 1'b0;
        if (s.button_raw != btn_prev[s.channel]) begin
            btn_prev[s.channel] = s.button_raw;
            hold_q[s.channel] = 0;
        end else if (hold_q[s.channel] < cfg_debounce) begin
            hold_q[s.channel]++;
        end else begin
            hold_q[s.channel] = cfg_debounce;
            if (s.button_raw != btn_settled[s.channel]) begin
                btn_settled[s.channel] = s.button_raw;
                press = !s.button_raw;
            end
        end
        if (press) mute_q[s.channel] = !mute_q[s.channel];
        r.level       = level_q[s.channel][LEVEL_W-1:0];
        r.mute        = mute_q[s.channel];
        r.detent_dir  = d;
        r.press_event = press;
        return r;
    endfunction

    // Next phase pair one quarter turn on, in either sense.
    function automatic logic [1:0] turn(input logic [1:0] ph, input logic cw);
        case (ph)
            PHASE_IDLE: return cw ? 2'b10 : 2'b01;
            2'b10:      return cw ? 2'b00 : PHASE_IDLE;
            2'b00:      return cw ? 2'b01 : 2'b10;
            default:    return cw ? PHASE_IDLE : 2'b00;
        endcase
    endfunction

    // Offers one sample, with random gaps, and records its expected report.
    task automatic put_sample(input pin_sample s, input bit known, input level_report want);
        level_report got;
        while (!steady_flow && $urandom_range(0, 99) < 37) begin
            smp_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        smp_bus.valid      <= 1'b1;
        smp_bus.channel    <= s.channel;
        smp_bus.phase_a    <= s.phase_a;
        smp_bus.phase_b    <= s.phase_b;
        smp_bus.button_raw <= s.button_raw;
        @(negedge i_clk);
        while (!smp_bus.ready) @(negedge i_clk);
        @(posedge i_clk);
        got = predict_sample(s);
        pending_reports.push_back(known ? want : got);
    endtask

    // Holds off new samples until every outstanding report has come back.
    task automatic settle_results();
        smp_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
    endtask

    // Writes all four registers and mirrors them in the predictor.
    task automatic apply_settings(input regime g);
        logic [CFG_IDX_W-1:0] idx_list [4];
        int unsigned          val_list [4];
        idx_list = '{CFG_LEVEL_STEP, CFG_LEVEL_MAX, CFG_DEBOUNCE_LIMIT, CFG_DETENT_COUNT};
        val_list = '{g.step_amt, g.top, g.deb, g.det};
        for (int k = 0; k < 4; k++) begin
            cfg_bus.valid <= 1'b1;
            cfg_bus.index <= idx_list[k];
            cfg_bus.data  <= val_list[k][CFG_DATA_W-1:0];
            @(negedge i_clk);
            while (!cfg_bus.ready) @(negedge i_clk);
            @(posedge i_clk);
            case (idx_list[k])
                CFG_LEVEL_STEP:     cfg_step     = val_list[k] & ((1 << LEVEL_W) - 1);
                CFG_LEVEL_MAX:      cfg_max      = val_list[k] & ((1 << LEVEL_W) - 1);
                CFG_DEBOUNCE_LIMIT: cfg_debounce = val_list[k] & ((1 << DEB_W) - 1);
                default:            cfg_detents  = val_list[k] & ((1 << DET_W) - 1);
            endcase
        end
        cfg_bus.valid <= 1'b0;
    endtask

    // Result side backpressure, lifted during the steady phase.
    always @(posedge i_clk) begin
        if (steady_flow) begin
            res_bus.ready <= 1'b1;
        end else begin
            res_bus.ready <= ($urandom_range(0, 99) >= 37);
        end
    end

    // A result transaction is checked at the falling clock edge ahead of the edge that takes it.
    always @(negedge i_clk) begin
        level_report want;
        if (i_rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            if (pending_reports.size() == 0) begin
                report_mismatch("report returned with none outstanding");
            end else begin
                want = pending_reports.pop_front();
                if (res_bus.channel_out !== want.channel_out)
                    report_mismatch($sformatf("channel_out %0d, expected %0d",
                                              res_bus.channel_out, want.channel_out));
                if (res_bus.level !== want.level)
                    report_mismatch($sformatf("ch %0d level %0d, expected %0d",
                                              want.channel_out, res_bus.level, want.level));
                if (res_bus.mute !== want.mute)
                    report_mismatch($sformatf("ch %0d mute %0b, expected %0b",
                                              want.channel_out, res_bus.mute, want.mute));
                if (res_bus.detent_dir !== want.detent_dir)
                    report_mismatch($sformatf("ch %0d detent_dir %0d, expected %0d",
                                              want.channel_out, res_bus.detent_dir,
                                              want.detent_dir));
                if (res_bus.press_event !== want.press_event)
                    report_mismatch($sformatf("ch %0d press_event %0b, expected %0b",
                                              want.channel_out, res_bus.press_event,
                                              want.press_event));
            end
        end
    end

    // Main sequence: reset, directed table, then phases of random traffic.
    initial begin
        regime       plan [5];
        pin_sample   s;
        logic [2:0]  ch;
        int unsigned sent;
        int unsigned r;
        bit          paused;

        i_rst_n            <= 1'b0;
        smp_bus.valid      <= 1'b0;
        smp_bus.channel    <= '0;
        smp_bus.phase_a    <= 1'b1;
        smp_bus.phase_b    <= 1'b1;
        smp_bus.button_raw <= 1'b1;
        cfg_bus.valid      <= 1'b0;
        cfg_bus.index      <= CFG_LEVEL_STEP;
        cfg_bus.data       <= '0;

        cfg_step     = int'(RST_LEVEL_STEP);
        cfg_max      = int'(RST_LEVEL_MAX);
        cfg_debounce = int'(RST_DEBOUNCE_LIMIT);
        cfg_detents  = int'(RST_DETENT_COUNT);
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            pin_state[i]   = PHASE_IDLE;
            turn_count[i]  = 0;
            btn_settled[i] = 1'b1;
            btn_prev[i]    = 1'b1;
            hold_q[i]      = 0;
            level_q[i]     = 0;
            mute_q[i]      = 1'b0;
        end
        for (int i = 0; i < 8; i++) begin
            enc_phase[i] = PHASE_IDLE;
            spin_cw[i]   = 1'b1;
            btn_level[i] = 1'b1;
            btn_run[i]   = 0;
        end

        // Reset defaults, both extremes, a mid setting and a random one.
        plan[0] = '{25, 1000, 19, 4, 80, 70, 1'b0};
        plan[1] = '{1023, 1023, 1, 1, 90, 60, 1'b1};
        plan[2] = '{1, 1, 255, 7, 230, 95, 1'b0};
        plan[3] = '{300, 1000, 3, 2, 80, 70, 1'b0};
        plan[4] = '{$urandom_range(1, 1023), $urandom_range(1, 1023), $urandom_range(1, 8),
                    $urandom_range(1, 7), 70, 70, 1'b0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (PROBES[i]) put_sample(PROBES[i].s, PROBES[i].known, PROBES[i].want);

        paused = 1'b0;
        ch = '0;
        for (int p = 0; p < 5; p++) begin
            settle_results();
            steady_flow = plan[p].steady;
            apply_settings(plan[p]);
            sent = 0;
            while (sent < plan[p].items) begin
                if ($urandom_range(0, 99) >= plan[p].stick) ch = 3'($urandom_range(0, 7));
                s.channel = ch;
                if (ch < NUM_CHANNELS) begin
                    // Mostly clean rotation with occasional reversals and phase noise.
                    r = $urandom_range(0, 99);
                    if (r < 8) spin_cw[ch] = !spin_cw[ch];
                    if (r < 70) begin
                        enc_phase[ch] = turn(enc_phase[ch], spin_cw[ch]);
                    end else if (r < 80) begin
                        enc_phase[ch] = turn(enc_phase[ch], !spin_cw[ch]);
                    end else if (r >= 92) begin
                        enc_phase[ch] = 2'($urandom_range(0, 3));
                    end
                    // Button held for runs around the debounce limit, with short glitches.
                    if (btn_run[ch] == 0) begin
                        btn_level[ch] = !btn_level[ch];
                        btn_run[ch] = ($urandom_range(0, 99) < 25) ? $urandom_range(1, 2)
                                    : $urandom_range(cfg_debounce + 1, cfg_debounce + 6);
                    end
                    btn_run[ch]--;
                    s.phase_a    = enc_phase[ch][1];
                    s.phase_b    = enc_phase[ch][0];
                    s.button_raw = btn_level[ch];
                end else begin
                    s.phase_a    = 1'($urandom_range(0, 1));
                    s.phase_b    = 1'($urandom_range(0, 1));
                    s.button_raw = 1'($urandom_range(0, 1));
                end
                sent++;
                put_sample(s, 1'b0, '0);
                if (p == 0 && sent == 40 && !paused) begin
                    paused = 1'b1;
                    settle_results();
                end
            end
        end

        settle_results();
        repeat (4) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/rel_pkg.sv
hw/rtl/rel_if.sv
hw/rtl/rel_chan_store.sv
hw/rtl/rel_update.sv
hw/rtl/rotary_encoder_level_and_mute.sv
dv/rotary_encoder_level_and_mute_tb.sv
